// ===== rtl/afbt_pkg.sv =====
// Package: shared types and codes for the failure block table.
`default_nettype none
package afbt_pkg;

	// request kinds
	localparam logic [1:0] REQ_CHECK = 2'd0;
	localparam logic [1:0] REQ_FAIL  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;
	localparam logic [1:0] CFG_BLOCK  = 2'd2;

	localparam logic [7:0]  LIMIT_RESET  = 8'd5;
	localparam logic [15:0] WINDOW_RESET = 16'd60;
	localparam logic [15:0] BLOCK_RESET  = 16'd60;
	localparam logic [7:0]  FAIL_MAX     = 8'hFF;

	typedef struct packed {
		logic [63:0] key;
		logic [7:0]  failures;
		logic [31:0] win_start;
		logic [31:0] block_end;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LK_RD,
		S_LK_CMP,
		S_DECIDE,
		S_CP_RD,
		S_CP_CHK,
		S_CP_END,
		S_CALC
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/auth_failure_block_table.sv =====
// Top level: per-client failure table with window counting and blocking.
//
// Usage: one request enters on the in channel (valid/ready) with req_type,
// client_key and now_seconds; exactly one result leaves on the out channel
// (valid/ready) with is_blocked, entry_found and failures_now. Registers are
// written over the cfg channel (index 0 limit, 1 window, 2 block length);
// cfg_ready is always high and writes are expected only while idle.
// One request is worked at a time. The lookup reads the used entries of the
// table memory one at a time until a hit, in a read state and a compare
// state each. A failure from a new client on a full table adds a compaction
// sweep over all N = TABLE_ENTRIES entries. Both scans go entry by entry
// because the table memory has a single read port.
// A finished result sits in the output register; the next request is taken
// meanwhile and only its final step waits while the receiver stalls.
// Reset empties the table (fill count zero) and loads the register defaults.
`default_nettype none
module auth_failure_block_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] client_key,
	input  wire logic [31:0] now_seconds,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_blocked,
	output logic             entry_found,
	output logic [7:0]       failures_now,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import afbt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int UW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [UW-1:0] FULL = UW'(TABLE_ENTRIES);

	// configuration registers
	logic [7:0]  limit_q;
	logic [15:0] window_q;
	logic [15:0] block_q;

	// control and request registers
	state_t        state_q, state_d;
	logic [1:0]    req_q;
	logic [63:0]   key_q;
	logic [31:0]   now_q;
	logic [UW-1:0] used_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] w_q;
	logic [IW-1:0] e_q;
	logic [IW-1:0] oldest_q;
	logic [31:0]   oldest_ff_q;
	logic          found_q;
	entry_t        ent_q;
	logic          out_valid_q;
	logic          blk_q;
	logic          fnd_q;
	logic [7:0]    fail_q;
	logic          keep_all_q;

	// table memory
	entry_t        mem [TABLE_ENTRIES];
	entry_t        rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	logic in_acc, out_free, last, keep, key_hit, lk_over, cp_over, older;
	entry_t upd;
	logic   upd_wr;

	function automatic logic window_over(input logic [31:0] now, input logic [31:0] ff,
		input logic [15:0] win);
		logic [32:0] d;
		d = {1'b0, now} - {1'b0, ff};
		return !d[32] && (d[31:0] > {16'd0, win});
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign is_blocked   = blk_q;
	assign entry_found  = fnd_q;
	assign failures_now = fail_q;

	// scan helpers
	assign last    = (UW'(i_q) + UW'(1)) == used_q;
	assign key_hit = rd_q.key == key_q;
	assign lk_over = window_over(now_q, rd_q.win_start, window_q);
	assign cp_over = lk_over;
	assign keep    = (rd_q.block_end > now_q) || ((rd_q.failures != 8'd0) && !cp_over);
	assign older   = (i_q == '0) || (rd_q.win_start < oldest_ff_q);

	// update of the selected entry
	always_comb begin
		logic [32:0] sum;
		upd    = ent_q;
		upd_wr = 1'b0;
		sum    = {1'b0, now_q} + {17'd0, block_q};
		if (req_q == REQ_FAIL) begin
			upd_wr = 1'b1;
			if (upd.failures != 8'd0 && window_over(now_q, upd.win_start, window_q))
				upd.failures = 8'd0;
			if (upd.failures == 8'd0)
				upd.win_start = now_q;
			if (upd.failures != FAIL_MAX)
				upd.failures = upd.failures + 8'd1;
			if (upd.failures >= limit_q)
				upd.block_end = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end else if (found_q && req_q == REQ_CHECK) begin
			upd_wr = 1'b1;
			if (upd.block_end <= now_q
				&& window_over(now_q, upd.win_start, window_q)) begin
				upd.failures  = 8'd0;
				upd.block_end = 32'd0;
			end
		end else if (found_q && req_q == REQ_CLEAR) begin
			upd_wr = 1'b1;
			upd.failures  = 8'd0;
			upd.block_end = 32'd0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = (used_q == '0) ? S_DECIDE : S_LK_RD;
			S_LK_RD:  state_d = S_LK_CMP;
			S_LK_CMP: begin
				if (key_hit || last) state_d = S_DECIDE;
				else state_d = S_LK_RD;
			end
			S_DECIDE: begin
				if (found_q || req_q != REQ_FAIL || used_q != FULL) state_d = S_CALC;
				else state_d = S_CP_RD;
			end
			S_CP_RD:  state_d = S_CP_CHK;
			S_CP_CHK: state_d = last ? S_CP_END : S_CP_RD;
			S_CP_END: state_d = S_CALC;
			S_CALC:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_addr = i_q;
		wr_en   = 1'b0;
		wr_addr = e_q;
		wr_data = upd;
		case (state_q)
			S_CP_CHK: begin
				wr_en   = keep && (w_q != i_q);
				wr_addr = w_q;
				wr_data = rd_q;
			end
			S_CALC: begin
				wr_en   = upd_wr && out_free;
				wr_addr = e_q;
				wr_data = upd;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			limit_q     <= LIMIT_RESET;
			window_q    <= WINDOW_RESET;
			block_q     <= BLOCK_RESET;
		end else begin
			state_q <= state_d;
			// result posted on leaving the last step, dropped once taken
			if (state_q == S_CALC && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_LIMIT:  limit_q  <= cfg_data[7:0];
					CFG_WINDOW: window_q <= cfg_data;
					CFG_BLOCK:  block_q  <= cfg_data;
					default:    limit_q  <= limit_q;
				endcase
			end
			case (state_q)
				S_DECIDE: if (!found_q && req_q == REQ_FAIL && used_q != FULL)
					used_q <= used_q + UW'(1);
				S_CP_END: used_q <= keep_all_q ? used_q : UW'(w_q) + UW'(1);
				default:  used_q <= used_q;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q   <= req_type;
					key_q   <= client_key;
					now_q   <= now_seconds;
					i_q     <= '0;
					found_q <= 1'b0;
					ent_q   <= '0;
				end
			end
			S_LK_CMP: begin
				if (older) begin
					oldest_q    <= i_q;
					oldest_ff_q <= rd_q.win_start;
				end
				if (key_hit) begin
					found_q <= 1'b1;
					e_q     <= i_q;
					ent_q   <= rd_q;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			S_DECIDE: begin
				i_q <= '0;
				w_q <= '0;
				if (!found_q) begin
					e_q   <= IW'(used_q);
					ent_q <= {key_q, 8'd0, 32'd0, 32'd0};
				end
			end
			S_CP_CHK: begin
				if (keep) w_q <= w_q + IW'(1);
				i_q <= i_q + IW'(1);
			end
			S_CP_END: begin
				// compaction left the table full: replace the oldest entry; else use the first freed slot
				if (keep_all_q) e_q <= oldest_q;
				else e_q <= w_q;
			end
			S_CALC: begin
				if (out_free) begin
					blk_q  <= upd.block_end > now_q;
					fnd_q  <= found_q;
					fail_q <= (found_q || req_q == REQ_FAIL) ? upd.failures : 8'd0;
				end
			end
			default: begin
				e_q <= e_q;
			end
		endcase
	end

	// every entry kept during compaction means the table is still full
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) keep_all_q <= 1'b1;
		else if (state_q == S_CP_CHK && !keep) keep_all_q <= 1'b0;
	end

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL) else $error("fill count beyond table size");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE) else $error("accepted request left no work");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC && out_free) |=> out_valid_q) else $error("result not posted");

endmodule
`default_nettype wire

// ===== bench/auth_failure_block_table_test.sv =====
// Testbench for the failure block table: random and directed requests checked against a predictor.
`default_nettype none
module auth_failure_block_table_test;
	import afbt_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int SLOTS = 16;
	localparam int DRAIN_CYCLES = 4 * SLOTS + 40;
	localparam int CYCLE_LIMIT = 1000000;

	// one expected answer for one request
	typedef struct {
		logic       blocked;
		logic       found;
		logic [7:0] fails;
	} verdict_t;

	// predictor of the table plus the queue of answers still owed
	class block_table_board;
		logic [63:0] keys [SLOTS];
		logic [7:0]  fails [SLOTS];
		logic [31:0] first_fail [SLOTS];
		logic [31:0] block_end [SLOTS];
		int          used;
		logic [7:0]  limit;
		logic [15:0] window;
		logic [15:0] block_len;
		verdict_t    owed_q [$];
		int          mismatches;

		function void clear_all();
			for (int i = 0; i < SLOTS; i++) begin
				keys[i] = '0;
				fails[i] = '0;
				first_fail[i] = '0;
				block_end[i] = '0;
			end
			used = 0;
			limit = LIMIT_RESET;
			window = WINDOW_RESET;
			block_len = BLOCK_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_LIMIT: limit = data[7:0];
				CFG_WINDOW: window = data;
				CFG_BLOCK: block_len = data;
				default: ;
			endcase
		endfunction

		// window elapsed: signed difference, so backwards time never expires
		function bit expired(int i, logic [31:0] now);
			longint d;
			d = $signed({32'd0, now}) - $signed({32'd0, first_fail[i]});
			return d > longint'({48'd0, window});
		endfunction

		function int find(logic [63:0] key);
			for (int i = 0; i < used; i++)
				if (keys[i] == key)
					return i;
			return -1;
		endfunction

		function void fresh(int i, logic [63:0] key);
			keys[i] = key;
			fails[i] = '0;
			first_fail[i] = '0;
			block_end[i] = '0;
		endfunction

		// drop records neither blocked nor counting, keeping order
		function void squeeze(logic [31:0] now);
			int w;
			bit keep;
			w = 0;
			for (int r = 0; r < used; r++) begin
				keep = (block_end[r] > now) || (fails[r] != 0 && !expired(r, now));
				if (keep) begin
					keys[w] = keys[r];
					fails[w] = fails[r];
					first_fail[w] = first_fail[r];
					block_end[w] = block_end[r];
					w++;
				end
			end
			used = w;
		endfunction

		function int place(logic [63:0] key, logic [31:0] now);
			int idx;
			int oldest;
			idx = find(key);
			if (idx >= 0)
				return idx;
			oldest = 0;
			for (int i = 1; i < used; i++)
				if (first_fail[i] < first_fail[oldest])
					oldest = i;
			if (used < SLOTS) begin
				fresh(used, key);
				used++;
				return used - 1;
			end
			squeeze(now);
			if (used < SLOTS) begin
				fresh(used, key);
				used++;
				return used - 1;
			end
			fresh(oldest, key);
			return oldest;
		endfunction

		// accepted request: update the table and queue its answer
		function void note_request(logic [1:0] req, logic [63:0] key, logic [31:0] now);
			int idx;
			int e;
			logic [32:0] fin;
			verdict_t v;
			idx = find(key);
			v.blocked = 1'b0;
			v.found = (idx >= 0);
			v.fails = '0;
			if (req == REQ_FAIL) begin
				e = place(key, now);
				if (fails[e] != 0 && expired(e, now))
					fails[e] = '0;
				if (fails[e] == 0)
					first_fail[e] = now;
				if (fails[e] != FAIL_MAX)
					fails[e]++;
				if (fails[e] >= limit) begin
					fin = {1'b0, now} + {17'd0, block_len};
					block_end[e] = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
				end
				v.blocked = block_end[e] > now;
				v.fails = fails[e];
			end else if (idx >= 0) begin
				if (req == REQ_CHECK) begin
					if (block_end[idx] <= now && expired(idx, now)) begin
						fails[idx] = '0;
						block_end[idx] = '0;
					end
				end else if (req == REQ_CLEAR) begin
					fails[idx] = '0;
					block_end[idx] = '0;
				end
				v.blocked = block_end[idx] > now;
				v.fails = fails[idx];
			end
			owed_q.push_back(v);
		endfunction

		function void check_result(logic blocked, logic found, logic [7:0] fcount);
			verdict_t v;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: blocked %0b found %0b failures %0d",
						blocked, found, fcount);
				return;
			end
			v = owed_q.pop_front();
			if (blocked !== v.blocked || found !== v.found || fcount !== v.fails) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %0b/%0b/%0d got %0b/%0b/%0d",
						v.blocked, v.found, v.fails, blocked, found, fcount);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [63:0] client_key;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_ready;
	logic        is_blocked;
	logic        entry_found;
	logic [7:0]  failures_now;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	block_table_board board;
	int          cycles = 0;
	int          results_seen = 0;
	logic [31:0] clock_s;
	logic [63:0] key_pool [$];

	auth_failure_block_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .client_key(client_key), .now_seconds(now_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_blocked(is_blocked), .entry_found(entry_found), .failures_now(failures_now),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off to fill the block
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_result(is_blocked, entry_found, failures_now);
				results_seen++;
				if (results_seen == 150)
					hold = 500;
			end
			if (hold == 0 && $urandom_range(0, 9) == 0)
				hold = pick_gap();
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one request; valid stays high for the caller to lower
	task automatic send_req(logic [1:0] req, logic [63:0] key, logic [31:0] now, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= req;
		client_key <= key;
		now_seconds <= now;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_request(req, key, now);
	endtask

	// wait for all answers, let any compaction settle, then write registers
	task automatic set_regs(logic [7:0] lim, logic [15:0] win, logic [15:0] blen);
		logic [15:0] vals [3];
		logic [1:0]  idxs [3];
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.owed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		idxs[0] = CFG_LIMIT;
		idxs[1] = CFG_WINDOW;
		idxs[2] = CFG_BLOCK;
		vals[0] = {8'($urandom), lim};
		vals[1] = win;
		vals[2] = blen;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			board.write_reg(idxs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random phase over a pool of clients with slowly advancing time
	task automatic run_phase(int n, int pool, logic [31:0] base, int max_step, bit burst);
		logic [1:0] req;
		int r;
		key_pool.delete();
		for (int i = 0; i < pool; i++)
			key_pool.push_back({$urandom, $urandom});
		clock_s = base;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				req = REQ_FAIL;
			else if (r < 83)
				req = REQ_CHECK;
			else if (r < 95)
				req = REQ_CLEAR;
			else
				req = REQ_UNKNOWN;
			if ($urandom_range(0, 49) == 0)
				clock_s = clock_s + $urandom_range(0, 2 * int'(board.window) + 2);
			else
				clock_s = clock_s + $urandom_range(0, max_step);
			send_req(req, key_pool[$urandom_range(0, pool - 1)], clock_s,
				burst ? 0 : pick_gap());
		end
	endtask

	initial begin
		logic [63:0] ka;
		board = new();
		board.clear_all();
		in_valid = 1'b0;
		req_type = '0;
		client_key = '0;
		now_seconds = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown clients, reaching the limit, unknown kind, clear, window restart
		ka = {$urandom, $urandom};
		send_req(REQ_CHECK, ka, 32'd100, 0);
		send_req(REQ_CLEAR, ka, 32'd100, 0);
		for (int i = 0; i < 5; i++)
			send_req(REQ_FAIL, ka, 32'd100 + i, pick_gap());
		send_req(REQ_CHECK, ka, 32'd110, 0);
		send_req(REQ_UNKNOWN, ka, 32'd110, 0);
		send_req(REQ_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd110, 0);
		send_req(REQ_CLEAR, ka, 32'd111, 0);
		send_req(REQ_CHECK, ka, 32'd111, 0);
		send_req(REQ_FAIL, ka, 32'd300, 0);
		send_req(REQ_CHECK, ka, 32'd400, 0);
		// time running backwards
		send_req(REQ_FAIL, ka, 32'd200, 0);
		send_req(REQ_FAIL, 64'd0, 32'hFFFF_FFF0, 0);
		send_req(REQ_FAIL, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_req(REQ_CHECK, 64'd0, 32'd0, 0);

		// limit zero, block end overflowing near the top of time
		set_regs(8'd0, 16'd0, 16'hFFFF);
		send_req(REQ_FAIL, ka, 32'hFFFF_FF00, 0);
		send_req(REQ_CHECK, ka, 32'hFFFF_FFFF, 0);
		run_phase(240, 20, 32'hFFFF_0000, 3, 1'b0);

		// one client hammered back to back with a high limit and a long window
		set_regs(8'd255, 16'hFFFF, 16'd1);
		run_phase(300, 1, $urandom, 2, 1'b1);

		// many clients, short window: compaction and eviction
		set_regs(8'd1, 16'd1, 16'd0);
		run_phase(250, 40, $urandom, 1, 1'b0);

		set_regs(8'd3, 16'd30, 16'd100);
		run_phase(250, 24, $urandom, 2, 1'b0);

		set_regs(8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom));
		run_phase(250, 18, $urandom, 4, 1'b0);

		set_regs(8'd5, 16'd60, 16'd60);
		run_phase(230, 17, $urandom, 1, 1'b0);

		// drain
		in_valid <= 1'b0;
		while (board.owed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.owed_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/afbt_pkg.sv
rtl/auth_failure_block_table.sv
bench/auth_failure_block_table_test.sv
